// File: rtl/core/mbdh_pkg.sv
// ----------------------------------------------------------------------------
// mbdh_pkg
// shared types and constants of the multi-button debouncer with hold detection
// ----------------------------------------------------------------------------
package mbdh_pkg;

    localparam int NUM_BUTTONS_DEF = 8;

    localparam int MASK_W   = 8;
    localparam int TRIG_W   = 8;
    localparam int HOLD_W   = 16;
    localparam int INTEG_W  = 9;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [TRIG_W-1:0] TRIGGER_RST = 8'd4;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 16'd500;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TRIGGER_COUNT      = 3'd0,
        CFG_HOLD_COUNT         = 3'd1,
        CFG_INVERT_MASK        = 3'd2,
        CFG_ENABLE_MASK        = 3'd3,
        CFG_RELEASE_AFTER_HOLD = 3'd4
    } t_cfg_idx;

    // per-button word kept in the state memory
    typedef struct packed {
        logic [INTEG_W-1:0] integ;
        logic [HOLD_W-1:0]  timer;
    } t_mem_word;

    typedef struct packed {
        logic               lvl;
        logic               st;
        logic               was_hold;
        logic [INTEG_W-1:0] integ;
        logic [HOLD_W-1:0]  timer;
    } t_btn_in;

    typedef struct packed {
        logic               st;
        logic               hold;
        logic [INTEG_W-1:0] integ;
        logic [HOLD_W-1:0]  timer;
        logic               pressed;
        logic               released;
        logic               held;
        logic               hold_ev;
    } t_btn_out;

endpackage

// File: rtl/core/multi_button_debounce_hold.sv
// ----------------------------------------------------------------------------
// multi_button_debounce_hold
// integrating debouncer with hold detection for a bank of buttons
// ----------------------------------------------------------------------------
// Each input beat is one scan tick of raw pin levels. The buttons are worked
// one per clock cycle, unless the pipeline halts, through a single
// read-modify-write pass over the per-button state memory (integrator and
// hold timer). A new tick is taken as the last button of the previous tick
// is issued. Each button passes the issue stage (memory read) and the update
// stage (write back and mask accumulation); the last button's masks go into
// the output register. The output register lets the next tick be taken and
// worked while a result still waits; the pipeline only halts when a second
// result is complete and the first has not left. Configuration writes are
// taken at any time and must only come while the block is idle.
// ----------------------------------------------------------------------------
module multi_button_debounce_hold
    import mbdh_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [MASK_W-1:0]   i_raw_levels,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [MASK_W-1:0]   o_level_mask,
    output logic [MASK_W-1:0]   o_pressed_mask,
    output logic [MASK_W-1:0]   o_released_mask,
    output logic [MASK_W-1:0]   o_held_mask,
    output logic                o_hold_event,

    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_idx,
    input  logic [CFG_DW-1:0]   i_cfg_data
);

    localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int XW = (IW > 3) ? IW : 3;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUTTONS - 1);

    // configuration
    logic [TRIG_W-1:0]  r_trigger_count;
    logic [HOLD_W-1:0]  r_hold_count;
    logic [MASK_W-1:0]  r_invert_mask;
    logic [MASK_W-1:0]  r_enable_mask;
    logic               r_release_after_hold;

    // issue stage
    logic               r_s1_busy;
    logic [IW-1:0]      r_s1_idx;
    logic [MASK_W-1:0]  r_s1_raw;
    logic               s1_last;

    // update stage
    logic               r2_valid;
    logic [IW-1:0]      r2_idx;
    logic [MASK_W-1:0]  r2_raw;
    logic               r2_last;

    // state memory and its read side
    t_mem_word          r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_vld;
    t_mem_word          r_rd_data;
    logic               r_rd_vld;
    logic               r_fwd;
    t_mem_word          r_fwd_data;

    logic [NUM_BUTTONS-1:0] r_state;
    logic [NUM_BUTTONS-1:0] r_hold;

    // accumulated masks and output register
    logic [MASK_W-1:0]  r_acc_level;
    logic [MASK_W-1:0]  r_acc_pressed;
    logic [MASK_W-1:0]  r_acc_released;
    logic [MASK_W-1:0]  r_acc_held;
    logic               r_acc_ev;

    logic               r_out_valid;
    logic [MASK_W-1:0]  r_out_level;
    logic [MASK_W-1:0]  r_out_pressed;
    logic [MASK_W-1:0]  r_out_released;
    logic [MASK_W-1:0]  r_out_held;
    logic               r_out_ev;

    logic               adv;
    logic               in_take;
    logic               out_take;
    logic               rd_en;
    logic               wr_en;

    logic [XW-1:0]      idx_x;
    logic [2:0]         bit_pos;
    logic               in_rng;
    logic               btn_en;
    t_mem_word          cur_word;
    t_mem_word          wr_word;
    t_btn_in            btn_in;
    t_btn_out           btn_out;

    logic [MASK_W-1:0]  n_acc_level;
    logic [MASK_W-1:0]  n_acc_pressed;
    logic [MASK_W-1:0]  n_acc_released;
    logic [MASK_W-1:0]  n_acc_held;
    logic               n_acc_ev;
    logic [MASK_W-1:0]  bit_sel;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_count      <= TRIGGER_RST;
            r_hold_count         <= HOLD_RST;
            r_invert_mask        <= '0;
            r_enable_mask        <= '0;
            r_release_after_hold <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TRIGGER_COUNT:      r_trigger_count      <= i_cfg_data[TRIG_W-1:0];
                CFG_HOLD_COUNT:         r_hold_count         <= i_cfg_data[HOLD_W-1:0];
                CFG_INVERT_MASK:        r_invert_mask        <= i_cfg_data[MASK_W-1:0];
                CFG_ENABLE_MASK:        r_enable_mask        <= i_cfg_data[MASK_W-1:0];
                CFG_RELEASE_AFTER_HOLD: r_release_after_hold <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and flow control
    // ------------------------------------------------------------------
    // halt only when a finished tick cannot move into a still-full output
    assign adv      = !(r2_valid && r2_last && r_out_valid && i_out_stall);
    assign s1_last  = (r_s1_idx == LAST_IDX);
    assign o_in_stall = !(adv && (!r_s1_busy || s1_last));
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign rd_en    = r_s1_busy && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_busy <= 1'b0;
            r_s1_idx  <= '0;
        end else if (in_take) begin
            r_s1_busy <= 1'b1;
            r_s1_idx  <= '0;
        end else if (rd_en) begin
            if (s1_last) begin
                r_s1_busy <= 1'b0;
            end else begin
                r_s1_idx <= r_s1_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_raw <= i_raw_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r_s1_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r2_idx  <= r_s1_idx;
            r2_raw  <= r_s1_raw;
            r2_last <= s1_last;
        end
    end

    // ------------------------------------------------------------------
    // per-button state memory, read in the issue stage ahead of the update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_s1_idx];
        end
        if (wr_en) begin
            r_mem[r2_idx] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_vld <= r_vld[r_s1_idx];
                // same entry written this cycle: the read returns stale data
                r_fwd    <= wr_en && (r2_idx == r_s1_idx);
            end
            if (wr_en) begin
                r_vld[r2_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_fwd_data <= wr_word;
        end
    end

    // ------------------------------------------------------------------
    // update stage
    // ------------------------------------------------------------------
    assign idx_x   = XW'(r2_idx);
    assign bit_pos = idx_x[2:0];
    assign in_rng  = ((idx_x >> 3) == '0);
    assign btn_en  = in_rng && r_enable_mask[bit_pos];
    assign bit_sel = in_rng ? (MASK_W'(1) << bit_pos) : '0;

    always_comb begin
        if (r_fwd) begin
            cur_word = r_fwd_data;
        end else if (r_rd_vld) begin
            cur_word = r_rd_data;
        end else begin
            cur_word = '0;
        end
    end

    always_comb begin
        btn_in.lvl      = r2_raw[bit_pos] ^ r_invert_mask[bit_pos];
        btn_in.st       = r_state[r2_idx];
        btn_in.was_hold = r_hold[r2_idx];
        btn_in.integ    = cur_word.integ;
        btn_in.timer    = cur_word.timer;
    end

    mbdh_btn_upd u_btn_upd (
        .i_btn                (btn_in),
        .i_trigger_count      (r_trigger_count),
        .i_hold_count         (r_hold_count),
        .i_release_after_hold (r_release_after_hold),
        .o_btn                (btn_out)
    );

    // disabled buttons keep their stored state untouched
    assign wr_en         = r2_valid && adv && btn_en;
    assign wr_word.integ = btn_out.integ;
    assign wr_word.timer = btn_out.timer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_hold  <= '0;
        end else if (wr_en) begin
            r_state[r2_idx] <= btn_out.st;
            r_hold[r2_idx]  <= btn_out.hold;
        end
    end

    always_comb begin
        if (r2_idx == '0) begin
            n_acc_level    = '0;
            n_acc_pressed  = '0;
            n_acc_released = '0;
            n_acc_held     = '0;
            n_acc_ev       = 1'b0;
        end else begin
            n_acc_level    = r_acc_level;
            n_acc_pressed  = r_acc_pressed;
            n_acc_released = r_acc_released;
            n_acc_held     = r_acc_held;
            n_acc_ev       = r_acc_ev;
        end
        if (btn_en) begin
            n_acc_level    = n_acc_level    | (btn_in.lvl       ? bit_sel : '0);
            n_acc_pressed  = n_acc_pressed  | (btn_out.pressed  ? bit_sel : '0);
            n_acc_released = n_acc_released | (btn_out.released ? bit_sel : '0);
            n_acc_held     = n_acc_held     | (btn_out.held     ? bit_sel : '0);
            n_acc_ev       = n_acc_ev | btn_out.hold_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid && adv) begin
            r_acc_level    <= n_acc_level;
            r_acc_pressed  <= n_acc_pressed;
            r_acc_released <= n_acc_released;
            r_acc_held     <= n_acc_held;
            r_acc_ev       <= n_acc_ev;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r2_valid && r2_last && adv) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid && r2_last && adv) begin
            r_out_level    <= n_acc_level;
            r_out_pressed  <= n_acc_pressed;
            r_out_released <= n_acc_released;
            r_out_held     <= n_acc_held;
            r_out_ev       <= n_acc_ev;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_mask    = r_out_level;
    assign o_pressed_mask  = r_out_pressed;
    assign o_released_mask = r_out_released;
    assign o_held_mask     = r_out_held;
    assign o_hold_event    = r_out_ev;

endmodule

// File: rtl/core/mbdh_btn_upd.sv
// ----------------------------------------------------------------------------
// mbdh_btn_upd
// one button's debounce integrator, state flip and hold timer update
// ----------------------------------------------------------------------------
module mbdh_btn_upd
    import mbdh_pkg::*;
(
    input  t_btn_in             i_btn,
    input  logic [TRIG_W-1:0]   i_trigger_count,
    input  logic [HOLD_W-1:0]   i_hold_count,
    input  logic                i_release_after_hold,
    output t_btn_out            o_btn
);

    logic [INTEG_W-1:0] thr;
    logic               diff;
    logic               flip;
    logic [INTEG_W-1:0] integ;
    logic [HOLD_W-1:0]  timer;
    logic               st;
    logic               hold;
    logic               pressed;
    logic               released;
    logic               hold_ev;

    assign thr  = {i_trigger_count, 1'b0};
    assign diff = i_btn.lvl ^ i_btn.st;

    always_comb begin
        integ    = i_btn.integ;
        timer    = i_btn.timer;
        st       = i_btn.st;
        hold     = i_btn.was_hold;
        pressed  = 1'b0;
        released = 1'b0;
        hold_ev  = 1'b0;

        if (diff) begin
            if (integ < thr) begin
                integ = integ + INTEG_W'(2);
            end
        end else if (integ != '0) begin
            integ = integ - INTEG_W'(1);
        end

        flip = diff && (integ >= thr);

        if (flip) begin
            if (i_btn.lvl) begin
                st      = 1'b1;
                integ   = '0;
                timer   = '0;
                pressed = 1'b1;
            end else begin
                st       = 1'b0;
                hold     = 1'b0;
                released = !i_btn.was_hold || i_release_after_hold;
            end
        end

        if (st) begin
            timer = timer + HOLD_W'(1);
            if (timer >= i_hold_count) begin
                hold    = 1'b1;
                timer   = '0;
                hold_ev = 1'b1;
            end
        end
    end

    always_comb begin
        o_btn.st       = st;
        o_btn.hold     = hold;
        o_btn.integ    = integ;
        o_btn.timer    = timer;
        o_btn.pressed  = pressed;
        o_btn.released = released;
        o_btn.held     = st && hold;
        o_btn.hold_ev  = hold_ev;
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-button debouncer with hold detection
// ----------------------------------------------------------------------------
// Scan ticks are sent through the input channel and checked against a
// predictor. The predictor keeps its own integrators, hold timers, debounced
// state and holding flags, and works out every result beat as the input beat
// is accepted. Directed ticks cover disabled buttons, zero thresholds, release
// after a hold and a lowered hold count. Random phases follow, mostly steady
// levels with bounce, under several register settings. Both channels idle and
// stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import mbdh_pkg::*;

    localparam int NB              = NUM_BUTTONS_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 4 * NB;
    localparam int MAX_REPORTS     = 50;

    typedef struct packed {
        logic [MASK_W-1:0] level;
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] held;
        logic              hold_ev;
    } t_scan_result;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [MASK_W-1:0]   i_raw_levels = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [MASK_W-1:0]   o_level_mask;
    logic [MASK_W-1:0]   o_pressed_mask;
    logic [MASK_W-1:0]   o_released_mask;
    logic [MASK_W-1:0]   o_held_mask;
    logic                o_hold_event;
    logic                i_cfg_we     = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_idx    = '0;
    logic [CFG_DW-1:0]   i_cfg_data   = '0;

    // predictor copy of the registers
    logic [TRIG_W-1:0]   cfg_trigger  = TRIGGER_RST;
    logic [HOLD_W-1:0]   cfg_hold     = HOLD_RST;
    logic [MASK_W-1:0]   cfg_invert   = '0;
    logic [MASK_W-1:0]   cfg_enable   = '0;
    logic                cfg_rah      = 1'b0;

    // predictor copy of the per-button state
    logic [INTEG_W-1:0]  integ_q [NB];
    logic [HOLD_W-1:0]   timer_q [NB];
    logic [MASK_W-1:0]   deb_state    = '0;
    logic [MASK_W-1:0]   hold_flags   = '0;

    t_scan_result        expected_scans[$];
    int                  errors       = 0;
    int                  idle_cycles  = 0;
    bit                  in_burst     = 1'b0;
    bit                  out_burst    = 1'b0;
    bit                  no_send_gaps = 1'b0;
    bit                  hold_off_req = 1'b0;

    multi_button_debounce_hold #(
        .NUM_BUTTONS(NB)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_levels   (i_raw_levels),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_level_mask   (o_level_mask),
        .o_pressed_mask (o_pressed_mask),
        .o_released_mask(o_released_mask),
        .o_held_mask    (o_held_mask),
        .o_hold_event   (o_hold_event),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // one scan tick through the integrators, timers and flags
    function automatic t_scan_result debounce_tick(input logic [MASK_W-1:0] raw);
        t_scan_result       res;
        logic [INTEG_W-1:0] thresh;
        logic               lvl;
        logic               st;
        logic               was_holding;
        res    = '0;
        thresh = {cfg_trigger, 1'b0};
        for (int b = 0; b < NB; b++) begin
            if (cfg_enable[b]) begin
                lvl = raw[b] ^ cfg_invert[b];
                st  = deb_state[b];
                res.level[b] = lvl;
                if (lvl != st) begin
                    if (integ_q[b] < thresh)
                        integ_q[b] = integ_q[b] + INTEG_W'(2);
                end else if (integ_q[b] != '0) begin
                    integ_q[b] = integ_q[b] - INTEG_W'(1);
                end
                if (lvl != st && integ_q[b] >= thresh) begin
                    if (lvl) begin
                        deb_state[b]   = 1'b1;
                        integ_q[b]     = '0;
                        timer_q[b]     = '0;
                        res.pressed[b] = 1'b1;
                    end else begin
                        was_holding   = hold_flags[b];
                        deb_state[b]  = 1'b0;
                        hold_flags[b] = 1'b0;
                        if (!was_holding || cfg_rah)
                            res.released[b] = 1'b1;
                    end
                end
                if (deb_state[b]) begin
                    timer_q[b] = timer_q[b] + HOLD_W'(1);
                    if (timer_q[b] >= cfg_hold) begin
                        hold_flags[b] = 1'b1;
                        timer_q[b]    = '0;
                        res.hold_ev   = 1'b1;
                    end
                    if (hold_flags[b])
                        res.held[b] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [MASK_W-1:0] want,
                                        input logic [MASK_W-1:0] got);
        if (got !== want) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_scan(input logic [MASK_W-1:0] raw);
        int gap;
        if ($urandom_range(0, 63) == 0)
            in_burst = !in_burst;
        gap = (in_burst || no_send_gaps) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_levels <= raw;
        do @(posedge i_clk); while (o_in_stall);
        expected_scans.push_back(debounce_tick(raw));
    endtask

    // sender pauses until every result beat is back
    task automatic drain_scans();
        i_in_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge i_clk);
    endtask

    // keeps the write enable high; apply_config lowers it after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [TRIG_W-1:0] trig, input logic [HOLD_W-1:0] hold,
                                input logic [MASK_W-1:0] inv, input logic [MASK_W-1:0] en,
                                input logic rah);
        drain_scans();
        write_reg(CFG_TRIGGER_COUNT,      CFG_DW'(trig));
        write_reg(CFG_HOLD_COUNT,         CFG_DW'(hold));
        write_reg(CFG_INVERT_MASK,        CFG_DW'(inv));
        write_reg(CFG_ENABLE_MASK,        CFG_DW'(en));
        write_reg(CFG_RELEASE_AFTER_HOLD, CFG_DW'(rah));
        i_cfg_we    <= 1'b0;
        cfg_trigger  = trig;
        cfg_hold     = hold;
        cfg_invert   = inv;
        cfg_enable   = en;
        cfg_rah      = rah;
    endtask

    // steady pressed levels that change now and then, with bounce on top
    task automatic test_random_scan(input int count, input int flip_div, input int noise_div);
        logic [MASK_W-1:0] target;
        logic [MASK_W-1:0] noise;
        logic [MASK_W-1:0] raw;
        target = deb_state;
        repeat (count) begin
            for (int b = 0; b < MASK_W; b++) begin
                if ($urandom_range(1, flip_div) == 1)
                    target[b] = !target[b];
                noise[b] = ($urandom_range(1, noise_div) == 1);
            end
            raw = target ^ noise ^ cfg_invert;
            if ($urandom_range(0, 15) == 0)
                raw = MASK_W'($urandom);
            send_scan(raw);
        end
    endtask

    task automatic test_disabled_after_reset();
        send_scan(8'hFF);
        send_scan(8'h00);
        send_scan(8'h5A);
    endtask

    // zero trigger flips at once, zero hold count signals on every pressed tick
    task automatic test_zero_thresholds();
        apply_config(8'd0, 16'd0, 8'h0F, 8'hFF, 1'b1);
        send_scan(8'h00);
        send_scan(8'hFF);
        send_scan(8'hF0);
        send_scan(8'h0F);
        send_scan(8'h00);
    endtask

    // release after a hold stays silent, a short press still reports its release
    task automatic test_hold_without_release();
        apply_config(8'd1, 16'd2, 8'h00, 8'hFF, 1'b0);
        repeat (4) send_scan(8'hFF);
        repeat (2) send_scan(8'h00);
        send_scan(8'hFF);
        send_scan(8'h00);
    endtask

    // timer already past the new hold count fires on the next pressed tick
    task automatic test_lowered_hold();
        apply_config(8'd1, 16'hFFFF, 8'h00, 8'h81, 1'b0);
        repeat (5) send_scan(8'h81);
        apply_config(8'd1, 16'd2, 8'h00, 8'h81, 1'b0);
        repeat (2) send_scan(8'h81);
        repeat (2) send_scan(8'h00);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            apply_config(TRIG_W'($urandom_range(1, 3)), HOLD_W'($urandom_range(1, 20)),
                         MASK_W'($urandom),
                         $urandom_range(0, 1) ? 8'hFF : MASK_W'($urandom),
                         1'($urandom_range(0, 1)));
            test_random_scan(200, 8, 16);
        end
    endtask

    task automatic test_slow_bounce();
        apply_config(TRIG_W'($urandom_range(4, 10)), HOLD_W'($urandom_range(20, 100)),
                     MASK_W'($urandom), 8'hFF, 1'b1);
        test_random_scan(500, 40, 10);
    endtask

    task automatic test_max_thresholds();
        apply_config(8'd255, 16'hFFFF, 8'hA5, 8'hFF, 1'b1);
        test_random_scan(400, 400, 32);
    endtask

    task automatic test_zero_trigger_noise();
        apply_config(8'd0, HOLD_W'($urandom_range(0, 3)), MASK_W'($urandom),
                     MASK_W'($urandom), 1'($urandom_range(0, 1)));
        test_random_scan(200, 2, 2);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_backpressure();
        apply_config(8'd2, 16'd10, 8'h00, 8'hFF, 1'b0);
        no_send_gaps = 1'b1;
        hold_off_req = 1'b1;
        test_random_scan(200, 8, 16);
        no_send_gaps = 1'b0;
    endtask

    initial begin
        for (int b = 0; b < NB; b++) begin
            integ_q[b] = '0;
            timer_q[b] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_after_reset();
        test_zero_thresholds();
        test_hold_without_release();
        test_lowered_hold();
        test_random_settings();
        test_slow_bounce();
        test_max_thresholds();
        test_zero_trigger_noise();
        test_output_backpressure();

        drain_scans();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side stall, drawn again after every accepted beat
    initial begin : result_stall
        int n;
        forever begin
            if ($urandom_range(0, 47) == 0)
                out_burst = !out_burst;
            n = out_burst ? 0 : $urandom_range(0, 15);
            if (hold_off_req) begin
                n = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_scan_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_scans.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result beat with no tick waiting, expected none, %s %h %h %h %h %b",
                             $time, "got", o_level_mask, o_pressed_mask,
                             o_released_mask, o_held_mask, o_hold_event);
                errors++;
            end else begin
                want = expected_scans.pop_front();
                check_field("level_mask",    want.level,    o_level_mask);
                check_field("pressed_mask",  want.pressed,  o_pressed_mask);
                check_field("released_mask", want.released, o_released_mask);
                check_field("held_mask",     want.held,     o_held_mask);
                check_field("hold_event",    MASK_W'(want.hold_ev), MASK_W'(o_hold_event));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
